// ===== hw/rtl/msfm_pkg.sv =====
// Types, codes and constants shared by the motion safety fault monitor.
`default_nettype none

package msfm_pkg;

    localparam int unsigned STALL_CONFIRM_DEF = 3;
    localparam int unsigned CNT_W             = 8;
    localparam int unsigned FLAG_W            = 5;
    localparam int unsigned CFG_IDX_W         = 4;
    localparam int unsigned CFG_DATA_W        = 32;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam int unsigned F_ENC   = 0;
    localparam int unsigned F_POS   = 1;
    localparam int unsigned F_VEL   = 2;
    localparam int unsigned F_STALL = 3;
    localparam int unsigned F_TIME  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MAX    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MIN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MAX    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_VALID_LOW   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_VALID_HIGH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_PERIOD_MS = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_MIN_DELTA = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIMEOUT_MS = 4'd7;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        now_ms;
        logic signed [31:0] position;
        logic [31:0]        vel_sps;
        logic [11:0]        adc_raw;
        logic               moving;
        logic [4:0]         clear_mask;
    } msfm_in_t;

    typedef struct packed {
        logic [4:0]  active_faults;
        logic [4:0]  new_faults;
        logic [31:0] elapsed_ms;
    } msfm_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msfm_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transfer.
`default_nettype none

interface msfm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/motion_safety_fault_monitor.sv =====
// Motion safety fault monitor: sample checks, stall detection and movement timeout.
//
// Usage:
//   sample : input stream of operations (update, movement start, movement end,
//            clear) with a millisecond timestamp and the motion readings.
//   result : one transfer per sample with the five fault flags, the newly
//            raised faults and the elapsed movement time.
//   cfg_*  : write-only register port (cfg_we, cfg_index, cfg_data); write
//            only while the monitor is idle. Indices above seven are ignored.
// Pipeline: a sample is held in the input register, then its result in the
//   result register, from which it is offered on result.
// Throughput: one sample per cycle while result is not held; the fault state
//   is updated as each sample leaves the input register, so the next sample sees it at once.
// Reset: all fault state clears and the registers return to their defaults
//   (open position and speed limits, full ADC window, 100 ms stall period,
//   minimum delta 1, 30000 ms timeout).
// Stall: while result is held, the input register keeps its sample and
//   sample.ready drops once it is full; nothing is lost or repeated.
`default_nettype none

module motion_safety_fault_monitor
    import msfm_pkg::*;
#(
    parameter int unsigned STALL_CONFIRM = STALL_CONFIRM_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    msfm_stream_if.sink                sample,
    msfm_stream_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic signed [31:0] position_max_reg;
    logic signed [31:0] position_min_reg;
    logic [31:0]        velocity_max_reg;
    logic [11:0]        adc_valid_low_reg;
    logic [11:0]        adc_valid_high_reg;
    logic [15:0]        stall_period_ms_reg;
    logic [15:0]        stall_min_delta_reg;
    logic [31:0]        move_timeout_ms_reg;

    // fault state
    logic [FLAG_W-1:0]  flags_reg,              flags_next;
    logic [CNT_W-1:0]   stall_counter_reg,      stall_counter_next;
    logic signed [31:0] stall_ref_position_reg, stall_ref_position_next;
    logic [31:0]        stall_check_time_reg,   stall_check_time_next;
    logic [31:0]        move_start_time_reg,    move_start_time_next;
    logic               move_active_reg,        move_active_next;

    // pipeline
    logic      in_valid_reg;
    msfm_in_t  in_data_reg;
    logic      out_valid_reg;
    msfm_out_t out_data_reg;
    logic      advance;

    // datapath
    logic               enc_bad;
    logic               pos_bad;
    logic               vel_bad;
    logic [31:0]        since_check;
    logic               check_due;
    logic signed [32:0] pos_diff;
    logic signed [32:0] delta_pos;
    logic signed [32:0] delta_neg;
    logic               no_progress;
    logic [CNT_W-1:0]   counter_inc;
    logic               stall_confirmed;
    logic [31:0]        elapsed;
    logic               timed_out;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // elapsed time is reported against the start time after this item
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_data_reg <= sample.data;
        end
        if (advance)
        begin
            out_data_reg.active_faults <= flags_next;
            out_data_reg.new_faults    <= flags_next & ~flags_reg;
            out_data_reg.elapsed_ms    <= in_data_reg.now_ms - move_start_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_max_reg    <= 32'sh7FFF_FFFF;
            position_min_reg    <= 32'sh8000_0000;
            velocity_max_reg    <= 32'hFFFF_FFFF;
            adc_valid_low_reg   <= 12'd0;
            adc_valid_high_reg  <= 12'd4095;
            stall_period_ms_reg <= 16'd100;
            stall_min_delta_reg <= 16'd1;
            move_timeout_ms_reg <= 32'd30000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POSITION_MAX:    position_max_reg    <= $signed(cfg_data[31:0]);
                CFG_POSITION_MIN:    position_min_reg    <= $signed(cfg_data[31:0]);
                CFG_VELOCITY_MAX:    velocity_max_reg    <= cfg_data[31:0];
                CFG_ADC_VALID_LOW:   adc_valid_low_reg   <= cfg_data[11:0];
                CFG_ADC_VALID_HIGH:  adc_valid_high_reg  <= cfg_data[11:0];
                CFG_STALL_PERIOD_MS: stall_period_ms_reg <= cfg_data[15:0];
                CFG_STALL_MIN_DELTA: stall_min_delta_reg <= cfg_data[15:0];
                CFG_MOVE_TIMEOUT_MS: move_timeout_ms_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // checks on the registered sample
    assign enc_bad = (in_data_reg.adc_raw < adc_valid_low_reg)
                  || (in_data_reg.adc_raw > adc_valid_high_reg);
    assign pos_bad = (in_data_reg.position > position_max_reg)
                  || (in_data_reg.position < position_min_reg);
    assign vel_bad = in_data_reg.vel_sps > velocity_max_reg;

    assign since_check = in_data_reg.now_ms - stall_check_time_reg;
    assign check_due   = since_check >= {16'd0, stall_period_ms_reg};

    // exact movement since reference; |diff| < delta as a window test
    assign pos_diff    = {in_data_reg.position[31], in_data_reg.position}
                       - {stall_ref_position_reg[31], stall_ref_position_reg};
    assign delta_pos   = $signed({17'd0, stall_min_delta_reg});
    assign delta_neg   = -delta_pos;
    assign no_progress = (pos_diff < delta_pos) && (pos_diff > delta_neg);

    assign counter_inc     = (stall_counter_reg == {CNT_W{1'b1}})
                           ? stall_counter_reg : stall_counter_reg + CNT_W'(1);
    assign stall_confirmed = counter_inc >= CNT_W'(STALL_CONFIRM);

    assign elapsed   = in_data_reg.now_ms - move_start_time_reg;
    assign timed_out = move_active_reg && in_data_reg.moving
                    && (elapsed > move_timeout_ms_reg);

    always_comb
    begin
        flags_next              = flags_reg;
        stall_counter_next      = stall_counter_reg;
        stall_ref_position_next = stall_ref_position_reg;
        stall_check_time_next   = stall_check_time_reg;
        move_start_time_next    = move_start_time_reg;
        move_active_next        = move_active_reg;
        case (in_data_reg.operation)
            OP_UPDATE:
            begin
                flags_next[F_ENC] = enc_bad;
                flags_next[F_POS] = pos_bad;
                flags_next[F_VEL] = vel_bad;
                if (in_data_reg.moving)
                begin
                    if (check_due)
                    begin
                        if (no_progress)
                        begin
                            stall_counter_next = counter_inc;
                            if (stall_confirmed)
                            begin
                                flags_next[F_STALL] = 1'b1;
                            end
                        end
                        else
                        begin
                            stall_counter_next  = '0;
                            flags_next[F_STALL] = 1'b0;
                        end
                        stall_ref_position_next = in_data_reg.position;
                        stall_check_time_next   = in_data_reg.now_ms;
                    end
                end
                else
                begin
                    stall_counter_next  = '0;
                    flags_next[F_STALL] = 1'b0;
                end
                if (timed_out)
                begin
                    flags_next[F_TIME] = 1'b1;
                end
            end
            OP_START:
            begin
                move_active_next        = 1'b1;
                move_start_time_next    = in_data_reg.now_ms;
                stall_ref_position_next = in_data_reg.position;
                stall_check_time_next   = in_data_reg.now_ms;
                stall_counter_next      = '0;
                flags_next[F_TIME]      = 1'b0;
            end
            OP_END:
            begin
                move_active_next    = 1'b0;
                stall_counter_next  = '0;
                flags_next[F_TIME]  = 1'b0;
                flags_next[F_STALL] = 1'b0;
            end
            default:
            begin
                flags_next = flags_reg & ~in_data_reg.clear_mask;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg              <= '0;
            stall_counter_reg      <= '0;
            stall_ref_position_reg <= '0;
            stall_check_time_reg   <= '0;
            move_start_time_reg    <= '0;
            move_active_reg        <= 1'b0;
        end
        else if (advance)
        begin
            flags_reg              <= flags_next;
            stall_counter_reg      <= stall_counter_next;
            stall_ref_position_reg <= stall_ref_position_next;
            stall_check_time_reg   <= stall_check_time_next;
            move_start_time_reg    <= move_start_time_next;
            move_active_reg        <= move_active_next;
        end
    end

    // newly raised faults are always among the reported flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.new_faults & ~out_data_reg.active_faults) == '0))
        else $error("new_faults not a subset of active_faults");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg.operation == OP_END)
            |=> (!flags_reg[F_STALL] && !flags_reg[F_TIME] && !move_active_reg))
        else $error("movement end left stall, timeout or movement armed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg.operation == OP_START)
            |=> (move_active_reg && stall_counter_reg == '0 && !flags_reg[F_TIME]))
        else $error("movement start did not arm monitoring");

    // a full input register that cannot drain must hold off new transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !sample.ready)
        else $error("sample accepted while input register blocked");

endmodule

`default_nettype wire

// ===== test/motion_safety_fault_monitor_tb.sv =====
// Self-checking testbench for the motion safety fault monitor: directed and random operations.
`timescale 1ns / 100ps

module motion_safety_fault_monitor_tb
    import msfm_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_TOTAL = 1550;
    localparam int PHASES = 10;
    localparam logic signed [31:0] POS_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_BOTTOM = 32'sh8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    class fault_monitor_board;
        logic signed [31:0] pos_max;
        logic signed [31:0] pos_min;
        logic [31:0]        vel_max;
        logic [11:0]        adc_lo;
        logic [11:0]        adc_hi;
        logic [15:0]        stall_period;
        logic [15:0]        stall_delta;
        logic [31:0]        move_timeout;
        logic [4:0]         flags;
        logic [7:0]         stall_cnt;
        logic signed [31:0] stall_ref;
        logic [31:0]        stall_time;
        logic [31:0]        start_time;
        bit                 move_on;
        msfm_out_t          expected_reports[$];
        int                 errors;

        function new();
            pos_max = POS_TOP;
            pos_min = POS_BOTTOM;
            vel_max = ALL_ONES;
            adc_lo = 12'd0;
            adc_hi = 12'hFFF;
            stall_period = 16'd100;
            stall_delta = 16'd1;
            move_timeout = 32'd30000;
            flags = '0;
            stall_cnt = '0;
            stall_ref = '0;
            stall_time = '0;
            start_time = '0;
            move_on = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POSITION_MAX:    pos_max = data;
                CFG_POSITION_MIN:    pos_min = data;
                CFG_VELOCITY_MAX:    vel_max = data;
                CFG_ADC_VALID_LOW:   adc_lo = data[11:0];
                CFG_ADC_VALID_HIGH:  adc_hi = data[11:0];
                CFG_STALL_PERIOD_MS: stall_period = data[15:0];
                CFG_STALL_MIN_DELTA: stall_delta = data[15:0];
                CFG_MOVE_TIMEOUT_MS: move_timeout = data;
                default: ;
            endcase
        endfunction

        function void note_sample(msfm_in_t s);
            logic [4:0]         prior;
            logic signed [31:0] pos;
            logic [31:0]        since;
            logic [31:0]        elapsed;
            longint             diff;
            msfm_out_t          e;
            prior = flags;
            pos = s.position;
            elapsed = s.now_ms - start_time;
            case (s.operation)
                OP_UPDATE:
                begin
                    flags[F_ENC] = (s.adc_raw < adc_lo) || (s.adc_raw > adc_hi);
                    flags[F_POS] = (pos > pos_max) || (pos < pos_min);
                    flags[F_VEL] = s.vel_sps > vel_max;
                    if (s.moving)
                    begin
                        since = s.now_ms - stall_time;
                        if (since >= {16'd0, stall_period})
                        begin
                            diff = longint'(pos) - longint'(stall_ref);
                            if (diff < 0)
                                diff = -diff;
                            if (diff < longint'(stall_delta))
                            begin
                                if (stall_cnt != 8'hFF)
                                    stall_cnt++;
                                if (stall_cnt >= STALL_CONFIRM_DEF)
                                    flags[F_STALL] = 1'b1;
                            end
                            else
                            begin
                                stall_cnt = '0;
                                flags[F_STALL] = 1'b0;
                            end
                            stall_ref = pos;
                            stall_time = s.now_ms;
                        end
                    end
                    else
                    begin
                        stall_cnt = '0;
                        flags[F_STALL] = 1'b0;
                    end
                    if (move_on && s.moving && elapsed > move_timeout)
                        flags[F_TIME] = 1'b1;
                end
                OP_START:
                begin
                    move_on = 1'b1;
                    start_time = s.now_ms;
                    stall_ref = pos;
                    stall_time = s.now_ms;
                    stall_cnt = '0;
                    flags[F_TIME] = 1'b0;
                    elapsed = '0;
                end
                OP_END:
                begin
                    move_on = 1'b0;
                    stall_cnt = '0;
                    flags[F_TIME] = 1'b0;
                    flags[F_STALL] = 1'b0;
                end
                default:
                    flags = flags & ~s.clear_mask;
            endcase
            e.active_faults = flags;
            e.new_faults = flags & ~prior;
            e.elapsed_ms = elapsed;
            expected_reports.push_back(e);
        endfunction

        function void check_report(msfm_out_t r);
            msfm_out_t e;
            if (expected_reports.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %p", r);
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            if (r.active_faults !== e.active_faults)
            begin
                $error("active_faults: expected %b, actual %b", e.active_faults,
                       r.active_faults);
                errors++;
            end
            if (r.new_faults !== e.new_faults)
            begin
                $error("new_faults: expected %b, actual %b", e.new_faults, r.new_faults);
                errors++;
            end
            if (r.elapsed_ms !== e.elapsed_ms)
            begin
                $error("elapsed_ms: expected %0d, actual %0d", e.elapsed_ms, r.elapsed_ms);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;
    int                    sent;
    logic [31:0]           t_ms;
    logic signed [31:0]    pos_cur;
    fault_monitor_board    sb;

    msfm_stream_if #(.payload_t(msfm_in_t))  sample_if ();
    msfm_stream_if #(.payload_t(msfm_out_t)) result_if ();

    motion_safety_fault_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic msfm_in_t mk(logic [1:0] op, logic [31:0] now, logic signed [31:0] pos,
                                    logic [31:0] vel, logic [11:0] adc, logic mv,
                                    logic [4:0] cm);
        msfm_in_t s;
        s.operation = op;
        s.now_ms = now;
        s.position = pos;
        s.vel_sps = vel;
        s.adc_raw = adc;
        s.moving = mv;
        s.clear_mask = cm;
        return s;
    endfunction

    function automatic logic [31:0] pick_speed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return sb.vel_max;
        if (r == 1)
            return sb.vel_max + 32'd1;
        if (r == 2)
            return $urandom;
        return $urandom_range(sb.vel_max);
    endfunction

    function automatic logic [11:0] pick_adc();
        case ($urandom_range(0, 9))
            0: return sb.adc_lo;
            1: return sb.adc_lo - 12'd1;
            2: return sb.adc_hi;
            3: return sb.adc_hi + 12'd1;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_sample(msfm_in_t s);
        int gap;
        sample_if.valid <= 1'b1;
        sample_if.data <= s;
        do @(posedge clk); while (!sample_if.ready);
        sb.note_sample(s);
        sent++;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // idle the input, let every result out, then allow for the pipeline
    task automatic wait_drain();
        sample_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_reports.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(logic signed [31:0] pmax, logic signed [31:0] pmin,
                                logic [31:0] vmax, logic [11:0] alo, logic [11:0] ahi,
                                logic [15:0] per, logic [15:0] dlt, logic [31:0] tmo);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_IDX_W-1:0]  idx [8];
        logic [31:0]           junk;
        wait_drain();
        idx = '{CFG_POSITION_MAX, CFG_POSITION_MIN, CFG_VELOCITY_MAX, CFG_ADC_VALID_LOW,
                CFG_ADC_VALID_HIGH, CFG_STALL_PERIOD_MS, CFG_STALL_MIN_DELTA,
                CFG_MOVE_TIMEOUT_MS};
        junk = $urandom;
        vals[0] = pmax;
        vals[1] = pmin;
        vals[2] = vmax;
        vals[3] = {junk[19:0], alo};
        vals[4] = {junk[31:12], ahi};
        vals[5] = {junk[15:0], per};
        vals[6] = {junk[31:16], dlt};
        vals[7] = tmo;
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        // out-of-range index, must be ignored
        cfg_index <= CFG_IDX_W'($urandom_range(CFG_MOVE_TIMEOUT_MS + 1, 2**CFG_IDX_W - 1));
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        int lo_pos;
        int hi_pos;
        int lo_adc;
        int hi_adc;
        int tmp;
        lo_pos = -int'($urandom_range(100, 5000));
        hi_pos = $urandom_range(100, 5000);
        lo_adc = $urandom_range(0, 2047);
        hi_adc = $urandom_range(2048, 4095);
        if ($urandom_range(0, 4) == 0)
        begin
            tmp = lo_pos;
            lo_pos = hi_pos;
            hi_pos = tmp;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            tmp = lo_adc;
            lo_adc = hi_adc;
            hi_adc = tmp;
        end
        write_config(hi_pos, lo_pos, $urandom_range(0, 100000), 12'(lo_adc), 12'(hi_adc),
                     16'($urandom_range(0, 200)), 16'($urandom_range(0, 20)),
                     $urandom_range(0, 3000));
    endtask

    task automatic motion_update(bit moving);
        int r;
        int dlt;
        r = $urandom_range(0, 9);
        if (r < 6)
            t_ms += $urandom_range(0, 2 * sb.stall_period + 2);
        else if (r < 8)
            t_ms += $urandom_range(0, 3);
        else if (r == 8)
            t_ms += $urandom_range(0, sb.move_timeout);
        else
            t_ms += $urandom;
        r = $urandom_range(0, 9);
        dlt = sb.stall_delta;
        if (r >= 4 && r < 7)
            pos_cur = pos_cur + (int'($urandom_range(0, 2 * dlt + 1)) - dlt);
        else if (r < 9 && r >= 7)
            pos_cur = pos_cur + (int'($urandom_range(0, 2000)) - 1000);
        else if (r == 9)
        begin
            case ($urandom_range(0, 3))
                0: pos_cur = sb.pos_max;
                1: pos_cur = sb.pos_max + 32'sd1;
                2: pos_cur = sb.pos_min;
                default: pos_cur = sb.pos_min - 32'sd1;
            endcase
        end
        send_sample(mk(OP_UPDATE, t_ms, pos_cur, pick_speed(), pick_adc(), moving,
                       5'($urandom)));
    endtask

    task automatic motion_sequence(int n);
        if ($urandom_range(0, 4) == 0)
            t_ms = $urandom;
        pos_cur = int'($urandom_range(0, 2000)) - 1000;
        send_sample(mk(OP_START, t_ms, pos_cur, $urandom, 12'($urandom), 1'($urandom),
                       5'($urandom)));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_sample(mk(OP_CLEAR, t_ms, $urandom, $urandom, 12'($urandom),
                               1'($urandom), 5'($urandom)));
            else
                motion_update($urandom_range(0, 99) < 85);
        end
        if ($urandom_range(0, 9) < 8)
            send_sample(mk(OP_END, t_ms, $urandom, $urandom, 12'($urandom), 1'($urandom),
                           5'($urandom)));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 5))
            send_sample(mk(2'($urandom), $urandom, $urandom, $urandom, 12'($urandom),
                           1'($urandom), 5'($urandom)));
    endtask

    // stall counter held at its ceiling: re-raises the stall flag right after a clear
    task automatic saturation_run();
        t_ms = 32'd5000;
        send_sample(mk(OP_START, t_ms, 32'sd77, 0, 0, 1'b0, 5'd0));
        repeat (300)
        begin
            t_ms++;
            send_sample(mk(OP_UPDATE, t_ms, 32'sd77, 0, 12'd2000, 1'b1, 5'd0));
        end
        send_sample(mk(OP_CLEAR, t_ms, 0, 0, 0, 1'b0, 5'(1 << F_STALL)));
        t_ms++;
        send_sample(mk(OP_UPDATE, t_ms, 32'sd77, 0, 12'd2000, 1'b1, 5'd0));
        send_sample(mk(OP_END, t_ms, 0, 0, 0, 1'b0, 5'd0));
    endtask

    task automatic directed_items();
        send_sample(mk(OP_UPDATE, 0, 0, 0, 0, 1'b0, 5'd0));
        send_sample(mk(OP_UPDATE, ALL_ONES, POS_TOP, ALL_ONES, 12'hFFF, 1'b1, 5'h1F));
        send_sample(mk(OP_UPDATE, 10, 1000, 500, 3000, 1'b0, 5'd0));
        send_sample(mk(OP_UPDATE, 11, -1001, 501, 99, 1'b0, 5'd0));
        send_sample(mk(OP_UPDATE, 12, -1000, 0, 100, 1'b0, 5'd0));
        send_sample(mk(OP_UPDATE, 13, 1001, 0, 3001, 1'b0, 5'd0));
        // movement across the time wrap
        send_sample(mk(OP_START, 32'hFFFF_FFF0, 0, ALL_ONES, 12'hFFF, 1'b1, 5'h1F));
        send_sample(mk(OP_UPDATE, 32'hFFFF_FFF0, 0, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_UPDATE, 32'hFFFF_FFF1, 0, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_UPDATE, 32'hFFFF_FFF2, 0, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_UPDATE, 32'h0000_0022, 4, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_UPDATE, 32'h0000_0023, 4, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_CLEAR, 32'h0000_0023, 0, 0, 0, 1'b0, 5'(1 << F_STALL)));
        send_sample(mk(OP_UPDATE, 32'h0000_0024, 4, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_UPDATE, 32'h0000_0025, POS_BOTTOM, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_UPDATE, 32'h0000_0026, 0, 0, 100, 1'b0, 5'd0));
        send_sample(mk(OP_END, 32'h0000_0030, 0, 0, 0, 1'b1, 5'h1F));
        send_sample(mk(OP_CLEAR, 32'h0000_0031, 0, 0, 0, 1'b0, 5'h1F));
        send_sample(mk(OP_CLEAR, 32'h0000_0032, 0, 0, 0, 1'b0, 5'd0));
        send_sample(mk(OP_UPDATE, 32'h0000_1000, 0, 0, 100, 1'b1, 5'd0));
        send_sample(mk(OP_START, 0, POS_BOTTOM, 0, 0, 1'b0, 5'd0));
        send_sample(mk(OP_END, 0, POS_TOP, 0, 0, 1'b0, 5'd0));
    endtask

    // result side: random back-pressure plus long holds so the input backs up
    initial
    begin
        int hold_left;
        int received;
        hold_left = 0;
        received = 0;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                sb.check_report(result_if.data);
                received++;
                if (received == 300 || received == 1100)
                    hold_left = 250;
            end
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                result_if.ready <= 1'b0;
                hold_left = idle_len();
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.data = '0;
        calm = 1'b0;
        sent = 0;
        t_ms = '0;
        pos_cur = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(1000, -1000, 500, 100, 3000, 0, 5, 50);
        directed_items();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph % 4 == 3);
            case (ph)
                0: write_config(POS_TOP, POS_BOTTOM, ALL_ONES, 12'd0, 12'hFFF, 16'hFFFF,
                                16'hFFFF, ALL_ONES);
                1: write_config(POS_BOTTOM, POS_TOP, 0, 12'hFFF, 12'd0, 16'd0, 16'd0, 0);
                2:
                begin
                    write_config(POS_TOP, POS_BOTTOM, ALL_ONES, 12'd0, 12'hFFF, 16'd0,
                                 16'hFFFF, ALL_ONES);
                    saturation_run();
                end
                default: random_config();
            endcase
            while (sent < ITEMS_TOTAL * (ph + 1) / PHASES)
            begin
                if ($urandom_range(0, 9) < 8)
                    motion_sequence($urandom_range(3, 25));
                else
                    noise_burst();
            end
        end

        wait_drain();
        repeat (6) @(posedge clk);
        if (sb.errors == 0 && sb.expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/msfm_pkg.sv
hw/rtl/msfm_stream_if.sv
hw/rtl/motion_safety_fault_monitor.sv
test/motion_safety_fault_monitor_tb.sv
